>>> sv/ciq_pkg.sv
// Types and codes shared by the coalescing input event queue.
package ciq_pkg;

   typedef enum logic [1:0] {
      ACT_PUSH  = 2'd0,
      ACT_POP   = 2'd1,
      ACT_RESET = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      SRC_TOUCH = 2'd0,
      SRC_MOUSE = 2'd1,
      SRC_KEY   = 2'd2,
      SRC_NONE  = 2'd3
   } source_type;

   typedef enum logic [3:0] {
      K_TOUCH_DOWN   = 4'd0,
      K_TOUCH_UP     = 4'd1,
      K_TOUCH_CANCEL = 4'd2,
      K_TOUCH_MOVE   = 4'd3,
      K_MOUSE_DOWN   = 4'd4,
      K_MOUSE_UP     = 4'd5,
      K_MOUSE_MOVE   = 4'd6,
      K_MOUSE_SCROLL = 4'd7,
      K_KEY_PRESS    = 4'd8,
      K_KEY_RELEASE  = 4'd9,
      K_RESET        = 4'd10
   } kind_type;

   localparam logic [7:0] CODE_DOWN       = 8'd0;
   localparam logic [7:0] CODE_UP         = 8'd1;
   localparam logic [7:0] CODE_CANCEL     = 8'd3;
   localparam logic [7:0] CODE_PTR_DOWN   = 8'd5;
   localparam logic [7:0] CODE_PTR_UP     = 8'd6;
   localparam logic [7:0] CODE_BTN_DOWN   = 8'd11;
   localparam logic [7:0] CODE_BTN_UP     = 8'd12;

   typedef struct packed {
      logic [1:0]         action;
      logic [1:0]         source;
      logic [7:0]         code;
      logic [15:0]        ident;
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
      logic [7:0]         press_level;
      logic signed [15:0] scroll_dx;
      logic signed [15:0] scroll_dy;
      logic [31:0]        meta_bits;
      logic [20:0]        char_point;
   } req_type;

   typedef struct packed {
      logic               popped_valid;
      logic [3:0]         event_type;
      logic [15:0]        out_ident;
      logic signed [19:0] out_x;
      logic signed [19:0] out_y;
      logic [7:0]         out_pressure;
      logic signed [15:0] out_scroll_dx;
      logic signed [15:0] out_scroll_dy;
      logic [31:0]        out_meta;
      logic [20:0]        out_char;
      logic [63:0]        out_time;
      logic [8:0]         pending_count;
   } rsp_type;

endpackage

>>> sv/coalescing_input_event_queue_core.sv
// Coalescing input event queue: classify, stamp, coalesce and store input events.
//
// Takes one command word per cycle (push, pop, reset with marker, clear) and returns
// exactly one result word per command, in the cycle after acceptance. Each command is
// handled in a single pass: the command is classified against the head, tail,
// occupancy and newest-entry registers, the entry memories see at most one write (new
// entry, coalesced tail update or reset marker) or one registered read (pop at head),
// and the result register captures the outcome. A new command is accepted every cycle
// unless the result register still holds an untaken word. Timestamps count accepted
// commands. Entries hold no reset value; the queue needs no clearing pass after reset.
module coalescing_input_event_queue_core
   import ciq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 256
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [3:0]  kind_mem  [QUEUE_DEPTH];
   logic [15:0] ident_mem [QUEUE_DEPTH];
   logic [39:0] pos_mem   [QUEUE_DEPTH];
   logic [7:0]  press_mem [QUEUE_DEPTH];
   logic [31:0] scroll_mem[QUEUE_DEPTH];
   logic [52:0] key_mem   [QUEUE_DEPTH];
   logic [63:0] stamp_mem [QUEUE_DEPTH];

   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic [CW-1:0] occ_ff, occ_in;
   kind_type      newest_kind_ff, newest_kind_in;
   logic [15:0]   newest_ident_ff, newest_ident_in;
   logic [63:0]   tick_ff, tick_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          hit_ff, hit_in;
   logic [8:0]    count_ff, count_in;

   logic [3:0]  kind_rd_ff;
   logic [15:0] ident_rd_ff;
   logic [39:0] pos_rd_ff;
   logic [7:0]  press_rd_ff;
   logic [31:0] scroll_rd_ff;
   logic [52:0] key_rd_ff;
   logic [63:0] stamp_rd_ff;

   logic          accept;
   kind_type      kind;
   logic          src_ok;
   logic [39:0]   pos_val;
   logic [7:0]    press_val;
   logic [31:0]   scroll_val;
   logic [52:0]   key_val;
   logic          occ_nz, full, is_move;
   logic          coal_mouse, coal_touch, do_push, enq;
   logic [AW-1:0] newest_slot;
   logic          we_all, we_pos, we_press, rd_en;
   logic [AW-1:0] wr_addr;
   kind_type      wr_kind;
   logic [15:0]   wr_ident;
   logic [39:0]   wr_pos;
   logic [7:0]    wr_press;
   logic [31:0]   wr_scroll;
   logic [52:0]   wr_key;
   logic [31:0]   occ_wide;

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i);
      logic [AW-1:0] r;
      if (i == AW'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = i + AW'(1);
      end
      return r;
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   // Classify the incoming event.
   always_comb begin
      pos_val    = {req_data.pos_y, req_data.pos_x};
      press_val  = req_data.press_level;
      scroll_val = {req_data.scroll_dy, req_data.scroll_dx};
      key_val    = {req_data.char_point, req_data.meta_bits};
      src_ok     = 1'b1;
      kind       = K_TOUCH_MOVE;
      case (source_type'(req_data.source))
         SRC_TOUCH: begin
            if (req_data.code == CODE_DOWN || req_data.code == CODE_PTR_DOWN) begin
               kind = K_TOUCH_DOWN;
            end else if (req_data.code == CODE_UP || req_data.code == CODE_PTR_UP) begin
               kind = K_TOUCH_UP;
            end else if (req_data.code == CODE_CANCEL) begin
               kind = K_TOUCH_CANCEL;
            end else begin
               kind = K_TOUCH_MOVE;
            end
            scroll_val = '0;
            key_val    = '0;
         end
         SRC_MOUSE: begin
            if (scroll_val != '0) begin
               kind = K_MOUSE_SCROLL;
            end else if (req_data.code == CODE_DOWN || req_data.code == CODE_BTN_DOWN) begin
               kind = K_MOUSE_DOWN;
            end else if (req_data.code == CODE_UP || req_data.code == CODE_BTN_UP) begin
               kind = K_MOUSE_UP;
            end else begin
               kind = K_MOUSE_MOVE;
            end
            press_val = '0;
            key_val   = '0;
         end
         SRC_KEY: begin
            kind       = (req_data.code != '0) ? K_KEY_PRESS : K_KEY_RELEASE;
            pos_val    = '0;
            press_val  = '0;
            scroll_val = '0;
         end
         default: begin
            src_ok = 1'b0;
         end
      endcase
   end

   assign occ_nz      = (occ_ff != '0);
   assign full        = (occ_ff == CW'(QUEUE_DEPTH));
   assign is_move     = (kind == K_TOUCH_MOVE) || (kind == K_MOUSE_MOVE);
   assign newest_slot = (tail_ff == '0) ? AW'(QUEUE_DEPTH - 1) : tail_ff - AW'(1);
   assign do_push     = accept && (action_type'(req_data.action) == ACT_PUSH) && src_ok;
   assign coal_mouse  = do_push && occ_nz && kind == K_MOUSE_MOVE
                        && newest_kind_ff == K_MOUSE_MOVE;
   assign coal_touch  = do_push && occ_nz && kind == K_TOUCH_MOVE
                        && newest_kind_ff == K_TOUCH_MOVE
                        && newest_ident_ff == req_data.ident;
   assign enq         = do_push && !coal_mouse && !coal_touch && !(full && is_move);

   // Advance queue pointers and build the memory access.
   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      occ_in          = occ_ff;
      newest_kind_in  = newest_kind_ff;
      newest_ident_in = newest_ident_ff;
      tick_in         = accept ? tick_ff + 64'd1 : tick_ff;
      we_all          = 1'b0;
      we_pos          = 1'b0;
      we_press        = 1'b0;
      rd_en           = 1'b0;
      hit_in          = hit_ff;
      wr_addr         = tail_ff;
      wr_kind         = kind;
      wr_ident        = req_data.ident;
      wr_pos          = pos_val;
      wr_press        = press_val;
      wr_scroll       = scroll_val;
      wr_key          = key_val;
      if (accept) begin
         hit_in = 1'b0;
         case (action_type'(req_data.action))
            ACT_PUSH: begin
               if (coal_mouse || coal_touch) begin
                  wr_addr  = newest_slot;
                  we_pos   = 1'b1;
                  we_press = coal_touch;
               end else if (enq) begin
                  we_all          = 1'b1;
                  we_pos          = 1'b1;
                  we_press        = 1'b1;
                  tail_in         = next_slot(tail_ff);
                  newest_kind_in  = kind;
                  newest_ident_in = req_data.ident;
                  if (full) begin
                     head_in = next_slot(head_ff);
                  end else begin
                     occ_in = occ_ff + CW'(1);
                  end
               end
            end
            ACT_POP: begin
               if (occ_nz) begin
                  rd_en   = 1'b1;
                  hit_in  = 1'b1;
                  head_in = next_slot(head_ff);
                  occ_in  = occ_ff - CW'(1);
               end
            end
            ACT_RESET: begin
               wr_addr         = '0;
               wr_kind         = K_RESET;
               wr_ident        = '0;
               wr_pos          = '0;
               wr_press        = '0;
               wr_scroll       = '0;
               wr_key          = '0;
               we_all          = 1'b1;
               we_pos          = 1'b1;
               we_press        = 1'b1;
               head_in         = '0;
               tail_in         = next_slot('0);
               occ_in          = CW'(1);
               newest_kind_in  = K_RESET;
               newest_ident_in = '0;
            end
            default: begin
               head_in = '0;
               tail_in = '0;
               occ_in  = '0;
            end
         endcase
      end
   end

   assign occ_wide = 32'(occ_in);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      count_in     = count_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         count_in     = occ_wide[8:0];
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we_all) begin
         kind_mem[wr_addr]   <= wr_kind;
         ident_mem[wr_addr]  <= wr_ident;
         scroll_mem[wr_addr] <= wr_scroll;
         key_mem[wr_addr]    <= wr_key;
      end
      if (we_pos) begin
         pos_mem[wr_addr]   <= wr_pos;
         stamp_mem[wr_addr] <= tick_ff;
      end
      if (we_press) begin
         press_mem[wr_addr] <= wr_press;
      end
      if (rd_en) begin
         kind_rd_ff   <= kind_mem[head_ff];
         ident_rd_ff  <= ident_mem[head_ff];
         pos_rd_ff    <= pos_mem[head_ff];
         press_rd_ff  <= press_mem[head_ff];
         scroll_rd_ff <= scroll_mem[head_ff];
         key_rd_ff    <= key_mem[head_ff];
         stamp_rd_ff  <= stamp_mem[head_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff         <= '0;
         tail_ff         <= '0;
         occ_ff          <= '0;
         newest_kind_ff  <= K_TOUCH_DOWN;
         newest_ident_ff <= '0;
         tick_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         hit_ff          <= 1'b0;
      end else begin
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         occ_ff          <= occ_in;
         newest_kind_ff  <= newest_kind_in;
         newest_ident_ff <= newest_ident_in;
         tick_ff         <= tick_in;
         rsp_valid_ff    <= rsp_valid_in;
         hit_ff          <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

   assign rsp_valid = rsp_valid_ff;

   // Zero all entry fields unless the command was a pop that found an entry.
   always_comb begin
      rsp_data               = '0;
      rsp_data.pending_count = count_ff;
      if (hit_ff) begin
         rsp_data.popped_valid  = 1'b1;
         rsp_data.event_type    = kind_rd_ff;
         rsp_data.out_ident     = ident_rd_ff;
         rsp_data.out_x         = pos_rd_ff[19:0];
         rsp_data.out_y         = pos_rd_ff[39:20];
         rsp_data.out_pressure  = press_rd_ff;
         rsp_data.out_scroll_dx = scroll_rd_ff[15:0];
         rsp_data.out_scroll_dy = scroll_rd_ff[31:16];
         rsp_data.out_meta      = key_rd_ff[31:0];
         rsp_data.out_char      = key_rd_ff[52:32];
         rsp_data.out_time      = stamp_rd_ff;
      end
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(QUEUE_DEPTH))
      else $error("occupancy above depth");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      (head_ff == tail_ff) == (occ_ff == '0 || occ_ff == CW'(QUEUE_DEPTH)))
      else $error("head, tail and occupancy disagree");

   a_pop_dec: assert property (@(posedge clock) disable iff (reset)
      (accept && action_type'(req_data.action) == ACT_POP && occ_nz)
      |=> (occ_ff == $past(occ_ff) - CW'(1)) && hit_ff)
      else $error("pop did not retire an entry");

   a_marker: assert property (@(posedge clock) disable iff (reset)
      (accept && action_type'(req_data.action) == ACT_RESET)
      |=> occ_ff == CW'(1) && newest_kind_ff == K_RESET && head_ff == '0)
      else $error("reset marker not queued");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(accept))
      else $error("result without accepted word");

endmodule
